// ===== rtl/lse_pkg.sv =====
// Shared types and constants for the five-point Laplacian entry generator.
// No dependencies; every other file of the block imports this package.
package lse_pkg;

    localparam int CELL_W    = 8;
    localparam int DIM_W     = 9;
    localparam int IDX_W     = 16;
    localparam int VAL_W     = 36;
    localparam int COEF_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int NENT      = 5;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0] MAX_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 9'd256;

    // boundary kinds
    localparam logic [KIND_W-1:0] KIND_DIRICHLET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEUMANN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PERIODIC  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MIX   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [COEF_W-1:0] cx;
        logic [COEF_W-1:0] cy;
        logic [KIND_W-1:0] kind_l;
        logic [KIND_W-1:0] kind_r;
        logic [KIND_W-1:0] kind_b;
        logic [KIND_W-1:0] kind_t;
    } t_cfg;

    // edge flags of a cell: at_* touches that side, neu_* that side is Neumann
    typedef struct packed {
        logic at_l;
        logic at_r;
        logic at_b;
        logic at_t;
        logic neu_l;
        logic neu_r;
        logic neu_b;
        logic neu_t;
    } t_edges;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              periodic;
        logic [CELL_W-1:0] ix;
        logic [CELL_W-1:0] jy;
        logic [CELL_W-1:0] xl;
        logic [CELL_W-1:0] xr;
        logic [CELL_W-1:0] yb;
        logic [CELL_W-1:0] yt;
        logic [DIM_W-1:0]  nx;
        t_edges            edges;
        logic [COEF_W-1:0] cx;
        logic [COEF_W-1:0] cy;
    } t_s1;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    periodic;
        logic [CELL_W-1:0]       ix;
        logic [CELL_W-1:0]       xl;
        logic [CELL_W-1:0]       xr;
        logic [IDX_W-1:0]        rb;
        logic [IDX_W-1:0]        bb;
        logic [IDX_W-1:0]        tb;
        t_edges                  edges;
        logic signed [VAL_W-1:0] dx;
        logic signed [VAL_W-1:0] dy;
        logic signed [VAL_W-1:0] ncx;
        logic signed [VAL_W-1:0] ncy;
    } t_s2;

    typedef struct packed {
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } t_ent;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  row;
        logic [CNT_W-1:0]  cnt;
        t_ent [NENT-1:0]   ent;
    } t_item;

endpackage

// ===== rtl/lse_decode.sv =====
// First stage: clamps the grid size, checks boundary mix and cell range,
// and works out wrapped neighbour coordinates. Depends on lse_pkg.
module lse_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_v,
    input  logic [lse_pkg::CELL_W-1:0] i_ix,
    input  logic [lse_pkg::CELL_W-1:0] i_jy,
    input  lse_pkg::t_cfg             i_cfg,
    output logic                      o_v,
    output lse_pkg::t_s1              o_s1
);
    import lse_pkg::*;

    logic              r_v;
    t_s1               r_s1;
    t_s1               n_s1;
    logic [DIM_W-1:0]  nx;
    logic [DIM_W-1:0]  ny;
    logic [DIM_W-1:0]  ix_p1;
    logic [DIM_W-1:0]  jy_p1;
    logic [DIM_W-1:0]  nx_m1;
    logic [DIM_W-1:0]  ny_m1;
    logic              mixed;
    logic              periodic;
    logic              out_rng;

    always_comb begin
        nx = (i_cfg.width > MAX_WIDTH) ? MAX_WIDTH : i_cfg.width;
        ny = (i_cfg.height > MAX_HEIGHT) ? MAX_HEIGHT : i_cfg.height;
        ix_p1 = {1'b0, i_ix} + 9'd1;
        jy_p1 = {1'b0, i_jy} + 9'd1;
        nx_m1 = nx - 9'd1;
        ny_m1 = ny - 9'd1;
        mixed = (i_cfg.kind_l < KIND_PERIODIC) && (i_cfg.kind_r < KIND_PERIODIC) &&
                (i_cfg.kind_b < KIND_PERIODIC) && (i_cfg.kind_t < KIND_PERIODIC);
        periodic = (i_cfg.kind_l == KIND_PERIODIC) && (i_cfg.kind_r == KIND_PERIODIC) &&
                   (i_cfg.kind_b == KIND_PERIODIC) && (i_cfg.kind_t == KIND_PERIODIC);
        out_rng = ({1'b0, i_ix} >= nx) || ({1'b0, i_jy} >= ny);

        n_s1.status   = (!mixed && !periodic) ? ST_MIX : (out_rng ? ST_RANGE : ST_OK);
        n_s1.periodic = periodic;
        n_s1.ix       = i_ix;
        n_s1.jy       = i_jy;
        n_s1.nx       = nx;
        n_s1.edges.at_l  = (i_ix == '0);
        n_s1.edges.at_r  = (ix_p1 == nx);
        n_s1.edges.at_b  = (i_jy == '0);
        n_s1.edges.at_t  = (jy_p1 == ny);
        n_s1.edges.neu_l = (i_cfg.kind_l == KIND_NEUMANN);
        n_s1.edges.neu_r = (i_cfg.kind_r == KIND_NEUMANN);
        n_s1.edges.neu_b = (i_cfg.kind_b == KIND_NEUMANN);
        n_s1.edges.neu_t = (i_cfg.kind_t == KIND_NEUMANN);
        // wrap to the far side at an edge; mixed mode never reads a wrapped value
        n_s1.xl = n_s1.edges.at_l ? nx_m1[CELL_W-1:0] : i_ix - 8'd1;
        n_s1.xr = n_s1.edges.at_r ? '0 : ix_p1[CELL_W-1:0];
        n_s1.yb = n_s1.edges.at_b ? ny_m1[CELL_W-1:0] : i_jy - 8'd1;
        n_s1.yt = n_s1.edges.at_t ? '0 : jy_p1[CELL_W-1:0];
        n_s1.cx = i_cfg.cx;
        n_s1.cy = i_cfg.cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_v;
        end
        if (i_adv) begin
            r_s1 <= n_s1;
        end
    end

    assign o_v  = r_v;
    assign o_s1 = r_s1;

endmodule

// ===== rtl/lse_index.sv =====
// Second stage: row base products (row times width) for the cell row and
// the rows below and above, plus the x and y parts of the diagonal.
// Depends on lse_pkg.
module lse_index (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  logic         i_v,
    input  lse_pkg::t_s1 i_s1,
    output logic         o_v,
    output lse_pkg::t_s2 o_s2
);
    import lse_pkg::*;

    logic                        r_v;
    t_s2                         r_s2;
    t_s2                         n_s2;
    logic [CELL_W+DIM_W-1:0]     p_rb;
    logic [CELL_W+DIM_W-1:0]     p_bb;
    logic [CELL_W+DIM_W-1:0]     p_tb;
    logic signed [VAL_W-1:0]     cx_s;
    logic signed [VAL_W-1:0]     cy_s;
    logic signed [VAL_W-1:0]     adj_l;
    logic signed [VAL_W-1:0]     adj_r;
    logic signed [VAL_W-1:0]     adj_b;
    logic signed [VAL_W-1:0]     adj_t;

    always_comb begin
        p_rb = {{DIM_W{1'b0}}, i_s1.jy} * {{CELL_W{1'b0}}, i_s1.nx};
        p_bb = {{DIM_W{1'b0}}, i_s1.yb} * {{CELL_W{1'b0}}, i_s1.nx};
        p_tb = {{DIM_W{1'b0}}, i_s1.yt} * {{CELL_W{1'b0}}, i_s1.nx};
        cx_s = $signed({{(VAL_W-COEF_W){1'b0}}, i_s1.cx});
        cy_s = $signed({{(VAL_W-COEF_W){1'b0}}, i_s1.cy});

        // Dirichlet edge adds c, Neumann edge takes c away
        adj_l = '0;
        adj_r = '0;
        adj_b = '0;
        adj_t = '0;
        if (!i_s1.periodic) begin
            if (i_s1.edges.at_l) adj_l = i_s1.edges.neu_l ? -cx_s : cx_s;
            if (i_s1.edges.at_r) adj_r = i_s1.edges.neu_r ? -cx_s : cx_s;
            if (i_s1.edges.at_b) adj_b = i_s1.edges.neu_b ? -cy_s : cy_s;
            if (i_s1.edges.at_t) adj_t = i_s1.edges.neu_t ? -cy_s : cy_s;
        end

        n_s2.status   = i_s1.status;
        n_s2.periodic = i_s1.periodic;
        n_s2.ix       = i_s1.ix;
        n_s2.xl       = i_s1.xl;
        n_s2.xr       = i_s1.xr;
        n_s2.rb       = p_rb[IDX_W-1:0];
        n_s2.bb       = p_bb[IDX_W-1:0];
        n_s2.tb       = p_tb[IDX_W-1:0];
        n_s2.edges    = i_s1.edges;
        n_s2.dx       = (cx_s <<< 1) + adj_l + adj_r;
        n_s2.dy       = (cy_s <<< 1) + adj_b + adj_t;
        n_s2.ncx      = -cx_s;
        n_s2.ncy      = -cy_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_v;
        end
        if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_v  = r_v;
    assign o_s2 = r_s2;

endmodule

// ===== rtl/lse_build.sv =====
// Third stage: final indices, diagonal sum, and the ordered list of one to
// five entries for the cell. Depends on lse_pkg.
module lse_build (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_v,
    input  lse_pkg::t_s2   i_s2,
    output logic           o_v,
    output lse_pkg::t_item o_item
);
    import lse_pkg::*;

    logic             r_v;
    t_item            r_item;
    t_item            n_item;
    logic [IDX_W-1:0] me;
    t_ent             ent_d;
    t_ent             ent_l;
    t_ent             ent_r;
    t_ent             ent_b;
    t_ent             ent_t;
    t_ent [NENT-1:0]  cand;
    logic [NENT-1:0]  keep;
    logic [CNT_W-1:0] pos;

    always_comb begin
        me        = i_s2.rb + {8'd0, i_s2.ix};
        ent_d.col = me;
        ent_d.val = i_s2.dx + i_s2.dy;
        ent_l.col = i_s2.rb + {8'd0, i_s2.xl};
        ent_l.val = i_s2.ncx;
        ent_r.col = i_s2.rb + {8'd0, i_s2.xr};
        ent_r.val = i_s2.ncx;
        ent_b.col = i_s2.bb + {8'd0, i_s2.ix};
        ent_b.val = i_s2.ncy;
        ent_t.col = i_s2.tb + {8'd0, i_s2.ix};
        ent_t.val = i_s2.ncy;

        if (i_s2.periodic) begin
            cand = {ent_t, ent_b, ent_r, ent_l, ent_d};
            keep = '1;
        end else begin
            cand = {ent_d, ent_t, ent_b, ent_r, ent_l};
            keep = {1'b1, !i_s2.edges.at_t, !i_s2.edges.at_b,
                    !i_s2.edges.at_r, !i_s2.edges.at_l};
        end

        // pack kept candidates to the front in order
        n_item.ent = '0;
        pos        = '0;
        for (int i = 0; i < NENT; i++) begin
            if (keep[i]) begin
                n_item.ent[pos] = cand[i];
                pos             = pos + 3'd1;
            end
        end
        n_item.cnt    = pos;
        n_item.row    = me;
        n_item.status = i_s2.status;

        if (i_s2.status != ST_OK) begin
            n_item.ent = '0;
            n_item.cnt = 3'd1;
            n_item.row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_v;
        end
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_v    = r_v;
    assign o_item = r_item;

endmodule

// ===== rtl/lse_emit.sv =====
// Output stage: holds one cell's entry list and sends one entry per cycle
// through registered result ports. Depends on lse_pkg.
module lse_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_v,
    input  lse_pkg::t_item             i_item,
    output logic                       o_take,
    output logic                       o_valid,
    output logic [lse_pkg::IDX_W-1:0]  o_mat_row,
    output logic [lse_pkg::IDX_W-1:0]  o_mat_col,
    output logic signed [lse_pkg::VAL_W-1:0] o_entry_value,
    output logic                       o_last_entry,
    output logic [lse_pkg::STAT_W-1:0] o_status
);
    import lse_pkg::*;

    t_ent [NENT-1:0]         r_ent;
    logic [CNT_W-1:0]        r_left;
    logic [IDX_W-1:0]        r_row;
    logic [STAT_W-1:0]       r_stat;
    logic                    r_o_valid;
    logic [IDX_W-1:0]        r_o_row;
    logic [IDX_W-1:0]        r_o_col;
    logic signed [VAL_W-1:0] r_o_val;
    logic                    r_o_last;
    logic [STAT_W-1:0]       r_o_stat;
    logic                    take;
    logic                    load;

    // free when empty or once the entry going out now is the last one held
    assign take = (r_left <= 3'd1);
    assign load = take && i_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (r_left != '0);
            if (load) begin
                r_left <= i_item.cnt;
            end else if (r_left != '0) begin
                r_left <= r_left - 3'd1;
            end
        end

        if (r_left != '0) begin
            r_o_row  <= r_row;
            r_o_col  <= r_ent[0].col;
            r_o_val  <= r_ent[0].val;
            r_o_last <= (r_left == 3'd1);
            r_o_stat <= r_stat;
        end

        if (load) begin
            r_ent  <= i_item.ent;
            r_row  <= i_item.row;
            r_stat <= i_item.status;
        end else begin
            // advance the list by one entry
            for (int i = 0; i < NENT - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
            r_ent[NENT-1] <= '0;
        end
    end

    assign o_take        = take;
    assign o_valid       = r_o_valid;
    assign o_mat_row     = r_o_row;
    assign o_mat_col     = r_o_col;
    assign o_entry_value = r_o_val;
    assign o_last_entry  = r_o_last;
    assign o_status      = r_o_stat;

endmodule

// ===== rtl/laplacian_stencil_entry_gen_unit.sv =====
// Top level of the five-point Laplacian entry generator: configuration
// registers, three compute stages and the output stage. Depends on lse_pkg.
//
// A cell request is taken when i_start is high and o_busy is low; it passes
// three register stages (decode, row-base multiply, entry build) and reaches
// the output stage, which holds its entry list and puts each entry on the
// registered result ports. Each cell yields one to five entries (five for an
// interior or periodic cell, one for an error), sent one per cycle with
// o_valid high for exactly one cycle each and o_last_entry marking the last;
// the receiver cannot stall them. The single output port sets the rate: a
// cell holds the pipeline until its last entry is going out, and o_busy
// rises when all compute stages are full and the output stage cannot load.
// Configuration writes are always ready and must be made while idle.
module laplacian_stencil_entry_gen_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [lse_pkg::CELL_W-1:0]    i_cell_col,
    input  logic [lse_pkg::CELL_W-1:0]    i_cell_row,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lse_pkg::COEF_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic [lse_pkg::IDX_W-1:0]     o_mat_row,
    output logic [lse_pkg::IDX_W-1:0]     o_mat_col,
    output logic signed [lse_pkg::VAL_W-1:0] o_entry_value,
    output logic                          o_last_entry,
    output logic [lse_pkg::STAT_W-1:0]    o_status
);
    import lse_pkg::*;

    t_cfg  r_cfg;
    logic  s1_v;
    logic  s2_v;
    logic  s3_v;
    t_s1   s1;
    t_s2   s2;
    t_item s3;
    logic  take;
    logic  adv1;
    logic  adv2;
    logic  adv3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 9'd1;
            r_cfg.height <= 9'd1;
            r_cfg.cx     <= '0;
            r_cfg.cy     <= '0;
            r_cfg.kind_l <= KIND_DIRICHLET;
            r_cfg.kind_r <= KIND_DIRICHLET;
            r_cfg.kind_b <= KIND_DIRICHLET;
            r_cfg.kind_t <= KIND_DIRICHLET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                CFG_COEF_X: r_cfg.cx     <= i_cfg_data;
                CFG_COEF_Y: r_cfg.cy     <= i_cfg_data;
                CFG_LEFT:   r_cfg.kind_l <= i_cfg_data[KIND_W-1:0];
                CFG_RIGHT:  r_cfg.kind_r <= i_cfg_data[KIND_W-1:0];
                CFG_BOTTOM: r_cfg.kind_b <= i_cfg_data[KIND_W-1:0];
                CFG_TOP:    r_cfg.kind_t <= i_cfg_data[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    assign adv3 = !s3_v || take;
    assign adv2 = !s2_v || adv3;
    assign adv1 = !s1_v || adv2;

    assign o_busy      = !adv1;
    assign o_cfg_ready = 1'b1;

    lse_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv1),
        .i_v     (i_start),
        .i_ix    (i_cell_col),
        .i_jy    (i_cell_row),
        .i_cfg   (r_cfg),
        .o_v     (s1_v),
        .o_s1    (s1)
    );

    lse_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_v     (s1_v),
        .i_s1    (s1),
        .o_v     (s2_v),
        .o_s2    (s2)
    );

    lse_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv3),
        .i_v     (s2_v),
        .i_s2    (s2),
        .o_v     (s3_v),
        .o_item  (s3)
    );

    lse_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_v           (s3_v),
        .i_item        (s3),
        .o_take        (take),
        .o_valid       (o_valid),
        .o_mat_row     (o_mat_row),
        .o_mat_col     (o_mat_col),
        .o_entry_value (o_entry_value),
        .o_last_entry  (o_last_entry),
        .o_status      (o_status)
    );

endmodule
